// ----- design/signed_int_to_decimal_ascii_core_macros.svh -----
// Assertion macros shared by the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ITOA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itoa assertion failed in the same cycle");

// Checks that the consequent holds in the cycle after the antecedent.
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itoa assertion failed one cycle later");

`endif

// ----- design/itoa_pkg.sv -----
// Types and constants shared by the decimal text converter.
`default_nettype none

package itoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;

    localparam t_char CHAR_MINUS = 8'd45;
    localparam t_char CHAR_ZERO  = 8'd48;

    typedef struct packed {
        logic clr;
        logic dabble;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- design/itoa_cell.sv -----
// One decimal digit cell of the shift-and-add-three conversion chain.
`default_nettype none

module itoa_cell (
    input  wire logic                 i_clk,
    input  wire itoa_pkg::t_cell_ctl  i_ctl,
    input  wire logic                 i_bit,
    input  wire itoa_pkg::t_digit     i_dig,
    output logic                      o_bit,
    output itoa_pkg::t_digit          o_dig
);

    itoa_pkg::t_digit r_dig;
    itoa_pkg::t_digit n_dig;
    itoa_pkg::t_digit w_adj;

    always_comb begin
        w_adj = (r_dig >= itoa_pkg::t_digit'(5)) ? r_dig + itoa_pkg::t_digit'(3) : r_dig;
        o_bit = w_adj[itoa_pkg::DIGIT_W-1];
        if (i_ctl.clr) begin
            n_dig = '0;
        end else if (i_ctl.dabble) begin
            n_dig = {w_adj[itoa_pkg::DIGIT_W-2:0], i_bit};
        end else if (i_ctl.shift) begin
            n_dig = i_dig;
        end else begin
            n_dig = r_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig <= n_dig;
    end

    assign o_dig = r_dig;

endmodule

`default_nettype wire

// ----- design/signed_int_to_decimal_ascii_core.sv -----
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// Each accepted item is converted by a chain of ten decimal digit cells that
// takes in the magnitude one bit a cycle; the chain then shifts one digit a
// cycle toward its top while the output is not stalled (leading zeros are
// dropped, not sent), and a minus sign is sent before the digits of a
// negative value. o_stall stays high until the final character is registered.
`default_nettype none

`include "signed_int_to_decimal_ascii_core_macros.svh"

module signed_int_to_decimal_ascii_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [itoa_pkg::VALUE_W-1:0]  i_value,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [itoa_pkg::CHAR_W-1:0]               o_char_code,
    output logic                                      o_last_char
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic [itoa_pkg::VALUE_W-1:0] r_mag, n_mag;
    logic [4:0] r_cnt, n_cnt;
    logic [3:0] r_rem, n_rem;
    logic r_sign, n_sign;
    logic r_started, n_started;
    logic r_o_valid, n_o_valid;
    itoa_pkg::t_char r_o_char, n_o_char;
    logic r_o_last, n_o_last;

    itoa_pkg::t_cell_ctl w_ctl;
    logic w_carry [itoa_pkg::NUM_DIGITS+1];
    itoa_pkg::t_digit w_dig [itoa_pkg::NUM_DIGITS+1];
    logic w_accept;
    logic w_out_free;
    logic w_is_last;
    logic w_emit_dig;
    itoa_pkg::t_digit w_top;

    assign w_carry[0] = r_mag[itoa_pkg::VALUE_W-1];
    assign w_dig[0]   = '0;
    assign w_top      = w_dig[itoa_pkg::NUM_DIGITS];

    for (genvar k = 0; k < itoa_pkg::NUM_DIGITS; k++) begin : g_cell
        itoa_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (w_ctl),
            .i_bit (w_carry[k]),
            .i_dig (w_dig[k]),
            .o_bit (w_carry[k+1]),
            .o_dig (w_dig[k+1])
        );
    end

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_is_last  = (r_rem == 4'd1);
    assign w_emit_dig = (w_top != '0) || r_started || w_is_last;

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_sign    = r_sign;
        n_started = r_started;
        n_o_valid = r_o_valid && i_stall;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        w_ctl     = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_sign    = i_value[itoa_pkg::VALUE_W-1];
                    n_mag     = i_value[itoa_pkg::VALUE_W-1] ? 32'd0 - i_value : i_value;
                    n_cnt     = '0;
                    n_started = 1'b0;
                    w_ctl.clr = 1'b1;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                w_ctl.dabble = 1'b1;
                n_mag        = {r_mag[itoa_pkg::VALUE_W-2:0], 1'b0};
                n_cnt        = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_rem   = 4'(itoa_pkg::NUM_DIGITS);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_sign) begin
                    if (w_out_free) begin
                        n_o_valid = 1'b1;
                        n_o_char  = itoa_pkg::CHAR_MINUS;
                        n_o_last  = 1'b0;
                        n_sign    = 1'b0;
                    end
                end else if (!w_emit_dig || w_out_free) begin
                    w_ctl.shift = 1'b1;
                    n_rem       = r_rem - 4'd1;
                    if (w_emit_dig) begin
                        n_o_valid = 1'b1;
                        n_o_char  = itoa_pkg::CHAR_ZERO + {4'd0, w_top};
                        n_o_last  = w_is_last;
                        n_started = 1'b1;
                    end
                    if (w_is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
            r_rem     <= '0;
            r_sign    <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_cnt     <= n_cnt;
            r_rem     <= n_rem;
            r_sign    <= n_sign;
            r_started <= n_started;
        end
        r_mag    <= n_mag;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

    assign o_valid     = r_o_valid;
    assign o_char_code = r_o_char;
    assign o_last_char = r_o_last;

    `ITOA_ASSERT_NOW(a_no_chain_overflow, i_clk, i_rst_n, r_state == S_CONV, !w_carry[itoa_pkg::NUM_DIGITS])
    `ITOA_ASSERT_NOW(a_rem_nonzero, i_clk, i_rst_n, r_state == S_EMIT, r_rem != 4'd0)
    `ITOA_ASSERT_NEXT(a_end_flags_last, i_clk, i_rst_n, r_state == S_EMIT && n_state == S_IDLE, o_valid && o_last_char)

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 100ps

typedef struct packed {
    itoa_pkg::t_char code;
    logic            last;
} t_char_item;

class decimal_text_board;
    t_char_item expected_chars[$];
    int         error_count;

    function new();
        error_count = 0;
    endfunction

    // Work out the characters that an accepted item must produce.
    function void note_value(logic [itoa_pkg::VALUE_W-1:0] bits);
        logic [itoa_pkg::VALUE_W-1:0] mag;
        itoa_pkg::t_digit             digits[itoa_pkg::NUM_DIGITS];
        int                           n;
        t_char_item                   item;
        n = 0;
        mag = bits[itoa_pkg::VALUE_W-1] ? (32'd0 - bits) : bits;
        do begin
            digits[n] = itoa_pkg::t_digit'(mag % 10);
            mag = mag / 10;
            n++;
        end while (mag != 0 && n < itoa_pkg::NUM_DIGITS);
        if (bits[itoa_pkg::VALUE_W-1]) begin
            item.code = itoa_pkg::CHAR_MINUS;
            item.last = 1'b0;
            expected_chars.push_back(item);
        end
        for (int i = n - 1; i >= 0; i--) begin
            item.code = itoa_pkg::CHAR_ZERO + itoa_pkg::t_char'(digits[i]);
            item.last = (i == 0);
            expected_chars.push_back(item);
        end
    endfunction

    task report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    task check_char(itoa_pkg::t_char code, logic last);
        t_char_item want;
        if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("char %0d with no item pending", code));
            return;
        end
        want = expected_chars.pop_front();
        if (code !== want.code) begin
            report_mismatch($sformatf("char code %0d, wanted %0d", code, want.code));
        end
        if (last !== want.last) begin
            report_mismatch($sformatf("last flag %0b, wanted %0b on char %0d",
                                      last, want.last, want.code));
        end
    endtask

    function int pending();
        return expected_chars.size();
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 400000;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic signed [itoa_pkg::VALUE_W-1:0] i_value;
    logic                                o_valid;
    logic                                i_stall;
    logic [itoa_pkg::CHAR_W-1:0]         o_char_code;
    logic                                o_last_char;

    decimal_text_board text_board = new();
    int                stall_pct = 0;
    int                cycle_count = 0;

    logic signed [itoa_pkg::VALUE_W-1:0] directed_values[] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
        32'sd2147483647, 32'sh80000000, -32'sd2147483647, 32'sd1000000000,
        32'sd999999999, -32'sd999999999, 32'sd123456789, -32'sd1234567890,
        32'sd2000000000, -32'sd5, 32'sd1000000001, 32'sh55555555, 32'shAAAAAAAA
    };

    signed_int_to_decimal_ascii_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            text_board.check_char(o_char_code, o_last_char);
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic signed [itoa_pkg::VALUE_W-1:0] random_value();
        longint span;
        longint mag;
        if ($urandom_range(3) == 0) begin
            return $urandom;
        end
        span = 1;
        repeat ($urandom_range(1, 10)) span = span * 10;
        mag = longint'({$urandom}) % span;
        return 32'($urandom_range(1) ? -mag : mag);
    endfunction

    task automatic send_value(logic signed [itoa_pkg::VALUE_W-1:0] value, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        text_board.note_value(value);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (text_board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_level);
        stall_pct = stall_level;
        for (int n = 0; n < count; n++) begin
            send_value(random_value(), idle_pct);
        end
        drain();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_values[n]) begin
            send_value(directed_values[n], 0);
        end
        drain();

        run_phase(47, 0, 0);
        run_phase(47, 53, 0);
        run_phase(47, 0, 53);
        run_phase(47, 35, 35);

        repeat (60) @(posedge i_clk);
        if (text_board.error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
